// ----- rtl/crcfrp_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfrp_pkg
// Shared types, constants and functions of the CRC framed report parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfrp_pkg;

   // frame layout
   localparam int HEADER_BYTES        = 7;
   localparam int MOUSE_PAYLOAD_BYTES = 8;
   localparam int CHECKSUM_BYTES      = 2;
   localparam int FRAME_MAX           = HEADER_BYTES + MOUSE_PAYLOAD_BYTES + CHECKSUM_BYTES;
   localparam int POS_W               = $clog2(FRAME_MAX + 1);

   // header byte places
   localparam int IDX_VERSION = 3;
   localparam int IDX_KIND    = 4;
   localparam int IDX_SEQ     = 5;
   localparam int IDX_LEN     = 6;

   // header codes
   localparam logic [7:0] SYNC0      = 8'h53;
   localparam logic [7:0] SYNC1      = 8'h49;
   localparam logic [7:0] SYNC2      = 8'h42;
   localparam logic [7:0] KIND_PROBE = 8'h00;
   localparam logic [7:0] KIND_MOUSE = 8'h01;

   // CRC-16 CCITT-FALSE
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] VERSION_RESET = 8'h01;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // stream widths; msg_kind travels on tuser, the rest on tdata
   localparam int REQ_DATA_W = 8;
   localparam int MSG_W      = 73;
   localparam int RSP_DATA_W = MSG_W - 1;

   // one parsed frame, msg_kind in the lowest bit
   typedef struct packed {
      logic signed [15:0] wheel_delta;
      logic signed [15:0] delta_y;
      logic signed [15:0] delta_x;
      logic [15:0]        button_bits;
      logic [7:0]         sequence_num;
      logic               msg_kind;
   } msg_type;

   // front to queue
   typedef struct packed {
      logic    valid;
      msg_type msg;
   } push_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // advance the CRC over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // type and length agree
   function automatic logic length_fits(input logic [7:0] kind, input logic [7:0] len);
      return ((kind == KIND_PROBE) && (len == 8'd0)) ||
             ((kind == KIND_MOUSE) && (len == 8'(MOUSE_PAYLOAD_BYTES)));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/crc_framed_report_parser_core.sv -----
// Result path: a good frame's message is written into the queue at the edge that
//   accepts its last byte, then loaded into the output register once that is free.
// Throughput: one byte per cycle; req_tready drops only while the message
//   queue is full, which needs QUEUE_DEPTH + 1 good frames behind a stalled rsp.
// Reset: synchronous, active high; clears the hunt position, the running CRC,
//   the queue and the output valid, and sets the protocol version to 1.
// ----------------------------------------------------------------------------
// crc_framed_report_parser_core
// Hunts for CRC-16 framed probe and mouse reports in a byte stream and emits
// one message per good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_report_parser_core
   import crcfrp_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item in
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // item out
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] sequence_num, [23:8] button_bits, [39:24] delta_x,
   // [55:40] delta_y, [71:56] wheel_delta
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,   // [0] msg_kind
   // protocol version write
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [7:0]            csr_data
);

   logic [7:0] version_ff;
   logic       take, pop;
   push_type   push;
   msg_type    head;
   qstat_type  stat;

   // version register
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (csr_valid && csr_ready) begin
         version_ff <= csr_data;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = !stat.full;
   assign take       = req_tvalid && req_tready;

   crcfrp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_tdata),
      .version (version_ff),
      .push    (push)
   );

   crcfrp_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .stat  (stat)
   );

   crcfrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a message is never offered to a full queue
   assert property (@(posedge clock) disable iff (reset) !(push.valid && stat.full))
      else $error("message pushed into full queue");

   // frames take at least nine bytes, so messages never come back to back
   assert property (@(posedge clock) disable iff (reset) push.valid |=> !push.valid)
      else $error("messages on consecutive cycles");

   // the output register only fills from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_tvalid) |-> $past(!stat.empty))
      else $error("result raised without queued message");

endmodule

`default_nettype wire

// ----- rtl/crcfrp_front.sv -----
// ----------------------------------------------------------------------------
// crcfrp_front
// Byte hunter: tracks the frame position, checks the header, runs the CRC
// and hands each good frame to the queue as one message.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfrp_front
   import crcfrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,        // a byte is accepted this cycle
   input  wire logic [7:0] rx_byte,
   input  wire logic [7:0] version,
   output push_type        push
);

   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_MAX);
   localparam logic [POS_W-1:0] POS_HDR   = POS_W'(HEADER_BYTES);
   localparam logic [8:0]       HDR_W9    = 9'(HEADER_BYTES);
   localparam logic [8:0]       DONE_BASE = 9'(HEADER_BYTES + CHECKSUM_BYTES);
   localparam int               IDX_PAY   = HEADER_BYTES;
   localparam int               IDX_LO_M  = HEADER_BYTES + MOUSE_PAYLOAD_BYTES;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       store_ff [FRAME_MAX];

   logic [POS_W-1:0] pos_cur, pos_nxt;
   logic             drop, hdr_fail, done, crc_take, frame_ok;
   logic [7:0]       len, kind, crc_lo;
   logic [15:0]      crc_step;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // frame bytes, no reset
   always_ff @(posedge clock) begin
      if (take && !drop) begin
         store_ff[pos_cur] <= rx_byte;
      end
   end

   always_comb begin
      pos_cur  = (pos_ff >= POS_LAST) ? '0 : pos_ff;
      pos_nxt  = pos_cur + POS_W'(1);
      len      = store_ff[IDX_LEN];
      kind     = store_ff[IDX_KIND];
      crc_lo   = (kind == KIND_MOUSE) ? store_ff[IDX_LO_M] : store_ff[IDX_PAY];
      drop     = (pos_cur == '0) && (rx_byte != SYNC0);

      // header and payload bytes go into the CRC
      crc_take = (pos_cur < POS_HDR) || ({{(9 - POS_W){1'b0}}, pos_cur} < HDR_W9 + {1'b0, len});
      crc_step = crc_byte((pos_cur == '0) ? CRC_INIT : crc_ff, rx_byte);

      // header checks on the byte just taken
      hdr_fail = ((pos_nxt == POS_W'(2)) && (rx_byte != SYNC1)) ||
                 ((pos_nxt == POS_W'(3)) && (rx_byte != SYNC2)) ||
                 ((pos_nxt == POS_W'(4)) && (rx_byte != version)) ||
                 ((pos_nxt == POS_W'(5)) && (rx_byte != KIND_PROBE) &&
                  (rx_byte != KIND_MOUSE)) ||
                 ((pos_nxt == POS_HDR) && !length_fits(kind, rx_byte));

      // last checksum byte of the frame
      done     = (pos_cur >= POS_HDR) &&
                 ({{(9 - POS_W){1'b0}}, pos_nxt} == DONE_BASE + {1'b0, len});
      frame_ok = (store_ff[IDX_VERSION] == version) && length_fits(kind, len) &&
                 (crc_ff == {rx_byte, crc_lo});

      pos_in = pos_ff;
      crc_in = crc_ff;
      if (take) begin
         if (drop) begin
            pos_in = '0;
            crc_in = CRC_INIT;
         end else if (hdr_fail) begin
            // restart; the offending byte opens a new frame if it is the first sync byte
            if (rx_byte == SYNC0) begin
               pos_in = POS_W'(1);
               crc_in = crc_byte(CRC_INIT, SYNC0);
            end else begin
               pos_in = '0;
               crc_in = CRC_INIT;
            end
         end else if (done) begin
            pos_in = '0;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_nxt;
            crc_in = crc_take ? crc_step : crc_ff;
         end
      end

      // message for a good frame
      push.valid            = take && !drop && !hdr_fail && done && frame_ok;
      push.msg.msg_kind     = kind[0];
      push.msg.sequence_num = store_ff[IDX_SEQ];
      if (kind == KIND_MOUSE) begin
         push.msg.button_bits = {store_ff[IDX_PAY + 1], store_ff[IDX_PAY]};
         push.msg.delta_x     = {store_ff[IDX_PAY + 3], store_ff[IDX_PAY + 2]};
         push.msg.delta_y     = {store_ff[IDX_PAY + 5], store_ff[IDX_PAY + 4]};
         push.msg.wheel_delta = {store_ff[IDX_PAY + 7], store_ff[IDX_PAY + 6]};
      end else begin
         push.msg.button_bits = '0;
         push.msg.delta_x     = '0;
         push.msg.delta_y     = '0;
         push.msg.wheel_delta = '0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/crcfrp_queue.sv -----
// ----------------------------------------------------------------------------
// crcfrp_queue
// Short message queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfrp_queue
   import crcfrp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output msg_type       head,
   output qstat_type     stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   msg_type       entry_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   always_comb begin
      stat.full  = (cnt_ff == CNT_FULL);
      stat.empty = (cnt_ff == '0);
      do_push    = push.valid && !stat.full;
      do_pop     = pop && !stat.empty;
      head       = entry_ff[rd_ff];

      // advance pointers with wrap
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + AW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push.msg;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/crcfrp_back.sv -----
// ----------------------------------------------------------------------------
// crcfrp_back
// Result side: pops messages from the queue into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfrp_back
   import crcfrp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire msg_type               head,
   input  wire qstat_type             stat,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser
);

   logic    valid_ff, valid_in;
   msg_type msg_ff;

   always_comb begin
      // refill when the output register is free or being taken
      pop      = !stat.empty && (!valid_ff || rsp_tready);
      valid_in = pop || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         msg_ff <= head;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = msg_ff.msg_kind;
   assign rsp_tdata  = {msg_ff.wheel_delta, msg_ff.delta_y, msg_ff.delta_x,
                        msg_ff.button_bits, msg_ff.sequence_num};

endmodule

`default_nettype wire

// ----- dv/crc_framed_report_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_framed_report_parser_core_tb
// Streams received bytes into the parser and checks every emitted message
// against an in-bench frame decoder. The stream mixes good probe and mouse
// frames with line noise, corrupted headers, bad CRCs and truncated frames.
// It runs under several protocol versions, with random gaps on both sides,
// one long result-side hold and one version change in the middle of a frame.
// ----------------------------------------------------------------------------

module crc_framed_report_parser_core_tb;
   import crcfrp_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] sequence_num, [23:8] button_bits, [39:24] delta_x,
   // [55:40] delta_y, [71:56] wheel_delta
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;          // [0] msg_kind
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data = '0;

   crc_framed_report_parser_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // byte stream still to send, and messages still owed by the block
   logic [7:0] byte_backlog[$];
   msg_type    msg_expected[$];
   logic [7:0] frame_buf[$];

   // decoder state
   logic [7:0]  version_reg = VERSION_RESET;
   logic [4:0]  hunt_pos = '0;
   logic [7:0]  frame_bytes[FRAME_MAX];
   logic [15:0] crc_acc = CRC_INIT;

   int  error_count    = 0;
   int  frames_checked = 0;
   int  bytes_sent     = 0;
   int  settings_used  = 1;
   int  idle_cycles    = 0;
   int  hold_asks      = 0;
   int  holds_done     = 0;
   bit  calm           = 1'b0;

   initial begin
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
   end

   // clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // CRC-16 CCITT-FALSE, one input bit at a time
   function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic bit kind_len_ok();
      if (frame_bytes[IDX_KIND] == KIND_PROBE) begin
         return frame_bytes[IDX_LEN] == 8'd0;
      end
      if (frame_bytes[IDX_KIND] == KIND_MOUSE) begin
         return frame_bytes[IDX_LEN] == 8'(MOUSE_PAYLOAD_BYTES);
      end
      return 1'b0;
   endfunction

   // advance the frame hunt by one byte; returns 1 when a good frame completes
   function automatic bit decode_byte(input logic [7:0] b, output msg_type m);
      logic [4:0]  pos;
      bit          hdr_bad;
      int unsigned want;
      int unsigned at;
      bit          ok;
      m   = '0;
      pos = hunt_pos;
      if (pos >= FRAME_MAX) begin
         pos     = '0;
         crc_acc = CRC_INIT;
      end
      // drop anything but a start byte while hunting
      if (pos == 0 && b != SYNC0) begin
         hunt_pos = '0;
         return 1'b0;
      end
      frame_bytes[pos] = b;
      if (pos == 0) begin
         crc_acc = crc16_update(CRC_INIT, b);
      end else if (pos < HEADER_BYTES || pos < HEADER_BYTES + frame_bytes[IDX_LEN]) begin
         crc_acc = crc16_update(crc_acc, b);
      end
      pos      = pos + 5'd1;
      hunt_pos = pos;

      hdr_bad = (pos == 2 && frame_bytes[1] != SYNC1) ||
                (pos == 3 && frame_bytes[2] != SYNC2) ||
                (pos == 4 && frame_bytes[IDX_VERSION] != version_reg) ||
                (pos == 5 && frame_bytes[IDX_KIND] != KIND_PROBE &&
                             frame_bytes[IDX_KIND] != KIND_MOUSE) ||
                (pos == HEADER_BYTES && !kind_len_ok());
      // restart the hunt, the offending byte may open a new frame
      if (hdr_bad) begin
         hunt_pos = '0;
         crc_acc  = CRC_INIT;
         if (b == SYNC0) begin
            frame_bytes[0] = b;
            crc_acc        = crc16_update(CRC_INIT, b);
            hunt_pos       = 5'd1;
         end
         return 1'b0;
      end

      want = (pos < HEADER_BYTES) ? HEADER_BYTES :
             HEADER_BYTES + frame_bytes[IDX_LEN] + CHECKSUM_BYTES;
      if (pos != want) begin
         return 1'b0;
      end

      // last byte: recheck version, length and CRC, then go idle either way
      at = HEADER_BYTES + frame_bytes[IDX_LEN];
      ok = frame_bytes[IDX_VERSION] == version_reg && kind_len_ok() && at + 1 < FRAME_MAX;
      if (ok) begin
         ok = crc_acc == {frame_bytes[at + 1], frame_bytes[at]};
      end
      hunt_pos = '0;
      crc_acc  = CRC_INIT;
      if (!ok) begin
         return 1'b0;
      end
      m.msg_kind     = frame_bytes[IDX_KIND][0];
      m.sequence_num = frame_bytes[IDX_SEQ];
      if (frame_bytes[IDX_KIND] == KIND_MOUSE) begin
         m.button_bits = {frame_bytes[HEADER_BYTES + 1], frame_bytes[HEADER_BYTES]};
         m.delta_x     = {frame_bytes[HEADER_BYTES + 3], frame_bytes[HEADER_BYTES + 2]};
         m.delta_y     = {frame_bytes[HEADER_BYTES + 5], frame_bytes[HEADER_BYTES + 4]};
         m.wheel_delta = {frame_bytes[HEADER_BYTES + 7], frame_bytes[HEADER_BYTES + 6]};
      end
      return 1'b1;
   endfunction

   // mostly short gaps, a few long ones, none in a calm stretch
   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH at message %0d, %s: got %h, expected %h",
               frames_checked, what, got, want);
      error_count++;
   endtask

   // byte driver: hold each item until accepted, then maybe idle
   always @(posedge clock) begin : req_driver
      msg_type fresh_msg;
      logic    next_valid;
      int      req_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap     = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            if (decode_byte(req_tdata, fresh_msg)) begin
               msg_expected.push_back(fresh_msg);
            end
            void'(byte_backlog.pop_front());
            bytes_sent++;
            next_valid = 1'b0;
            req_gap    = pick_gap();
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (byte_backlog.size() > 0) begin
               next_valid = 1'b1;
               req_tdata <= byte_backlog[0];
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // message monitor: check each accepted item, stall at random
   always @(posedge clock) begin : rsp_monitor
      msg_type got;
      msg_type want;
      int      stall_left;
      int      hold_left;
      logic    next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
         hold_left   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser};
            if (msg_expected.size() == 0) begin
               report_mismatch("message with none expected", 16'(got.sequence_num), '0);
            end else begin
               want = msg_expected.pop_front();
               if (got.msg_kind !== want.msg_kind)
                  report_mismatch("msg_kind", 16'(got.msg_kind), 16'(want.msg_kind));
               if (got.sequence_num !== want.sequence_num)
                  report_mismatch("sequence_num", 16'(got.sequence_num),
                                  16'(want.sequence_num));
               if (got.button_bits !== want.button_bits)
                  report_mismatch("button_bits", got.button_bits, want.button_bits);
               if (got.delta_x !== want.delta_x)
                  report_mismatch("delta_x", got.delta_x, want.delta_x);
               if (got.delta_y !== want.delta_y)
                  report_mismatch("delta_y", got.delta_y, want.delta_y);
               if (got.wheel_delta !== want.wheel_delta)
                  report_mismatch("wheel_delta", got.wheel_delta, want.wheel_delta);
            end
            frames_checked++;
         end
         if (hold_asks != holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
         rsp_tready <= next_ready;
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d messages owed",
                     IDLE_LIMIT, msg_expected.size());
            $display("** crc_framed_report_parser_core: FAILED **");
            $finish;
         end
      end
   end

   // four 16-bit payload words, now and then an extreme value
   function automatic logic [63:0] random_payload();
      logic [63:0] p;
      for (int w = 0; w < 4; w++) begin
         case ($urandom_range(0, 7))
            0:       p[16*w +: 16] = 16'h0000;
            1:       p[16*w +: 16] = 16'hFFFF;
            2:       p[16*w +: 16] = 16'h7FFF;
            3:       p[16*w +: 16] = 16'h8000;
            default: p[16*w +: 16] = 16'($urandom_range(0, 65535));
         endcase
      end
      return p;
   endfunction

   // assemble one well-formed frame into frame_buf
   task automatic build_frame(input logic [7:0] kind, input logic [7:0] seq,
                              input logic [7:0] ver, input logic [63:0] payload);
      logic [15:0] c;
      int          n;
      frame_buf.delete();
      n = (kind == KIND_MOUSE) ? MOUSE_PAYLOAD_BYTES : 0;
      frame_buf.push_back(SYNC0);
      frame_buf.push_back(SYNC1);
      frame_buf.push_back(SYNC2);
      frame_buf.push_back(ver);
      frame_buf.push_back(kind);
      frame_buf.push_back(seq);
      frame_buf.push_back(8'(n));
      for (int i = 0; i < n; i++) begin
         frame_buf.push_back(payload[8*i +: 8]);
      end
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc16_update(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic queue_frame();
      foreach (frame_buf[i]) byte_backlog.push_back(frame_buf[i]);
   endtask

   task automatic good_frame();
      build_frame(($urandom_range(0, 9) < 3) ? KIND_PROBE : KIND_MOUSE,
                  8'($urandom_range(0, 255)), version_reg, random_payload());
      queue_frame();
   endtask

   // mostly good frames, the rest noise and damaged frames
   task automatic random_traffic(input int n_bytes);
      int added;
      int sel;
      int at;
      added = 0;
      while (added < n_bytes) begin
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_frame(($urandom_range(0, 9) < 3) ? KIND_PROBE : KIND_MOUSE,
                        8'($urandom_range(0, 255)), version_reg, random_payload());
            // damage one byte, sometimes cut the frame short after it
            if (sel >= 72) begin
               at = $urandom_range(1, frame_buf.size() - 1);
               frame_buf[at] = ($urandom_range(0, 3) == 0) ? SYNC0
                                                            : 8'($urandom_range(0, 255));
               if ($urandom_range(0, 3) == 0) begin
                  while (frame_buf.size() > at + 1) void'(frame_buf.pop_back());
               end
            end
         end
         added += frame_buf.size();
         queue_frame();
      end
   endtask

   // hold until every byte is in and every owed message is out
   task automatic wait_drained();
      while (byte_backlog.size() != 0 || req_tvalid || msg_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_version(input logic [7:0] v);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      version_reg = v;
      csr_valid  <= 1'b0;
      settings_used++;
   endtask

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle noise, a stray start byte before a probe, an extreme mouse report
      byte_backlog.push_back(8'h00);
      byte_backlog.push_back(8'hFF);
      byte_backlog.push_back(SYNC0);
      build_frame(KIND_PROBE, 8'h00, version_reg, '0);
      queue_frame();
      build_frame(KIND_MOUSE, 8'hFF, version_reg, {16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF});
      queue_frame();
      random_traffic(80);

      // change the version while a frame is half received
      build_frame(KIND_MOUSE, 8'h5A, version_reg, random_payload());
      repeat (10) byte_backlog.push_back(frame_buf.pop_front());
      write_version(8'h00);
      queue_frame();
      random_traffic(90);

      // long result-side hold while the sender keeps offering frames
      write_version(8'hFF);
      hold_asks++;
      repeat (8) good_frame();
      random_traffic(60);

      // a stretch with no idling on either side
      write_version(8'($urandom_range(2, 254)));
      calm = 1'b1;
      random_traffic(90);
      wait_drained();
      calm = 1'b0;

      write_version(SYNC0);
      random_traffic(90);

      write_version(VERSION_RESET);
      random_traffic(90);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes, checked %0d messages over %0d version settings",
               bytes_sent, frames_checked, settings_used);
      $display("Stream held noise, damaged frames, a mid-frame version change and a long hold");
      if (error_count == 0) begin
         $display("** crc_framed_report_parser_core: PASSED **");
      end else begin
         $display("** crc_framed_report_parser_core: FAILED **");
      end
      $finish;
   end

endmodule
